// ===== sv/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants of the link packet framer
// Result entry layout, frame descriptor and register indexes.
// ----------------------------------------------------------------------------
package lpf_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned MAX_RES    = 6;
	localparam int unsigned CNT_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 8'd1;

	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              frame_end;
		logic              error;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]          count;
		result_t [MAX_RES-1:0]     ent;
	} frame_t;

endpackage

// ===== sv/lpf_engine.sv =====
// ----------------------------------------------------------------------------
// lpf_engine: packet state, checksum and frame builder
// Holds the start bytes, packet state and running sums, and forms the
// results of one input transaction in a single pass.
// ----------------------------------------------------------------------------
module lpf_engine #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [lpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpf_pkg::BYTE_W-1:0]        cfg_data,
	input  logic                              load,
	input  logic                              operation,
	input  logic [lpf_pkg::BYTE_W-1:0]        packet_type,
	input  logic [lpf_pkg::BYTE_W-1:0]        payload_length,
	input  logic [lpf_pkg::BYTE_W-1:0]        data_byte,
	output lpf_pkg::frame_t                   frame
);

	localparam logic [lpf_pkg::BYTE_W-1:0] MAX_LEN = lpf_pkg::BYTE_W'(MAX_PAYLOAD);

	logic [lpf_pkg::BYTE_W-1:0] start_one_q, start_two_q;
	logic                       open_q;
	logic [lpf_pkg::BYTE_W-1:0] remaining_q, sum_low_q, sum_high_q;

	logic                       hdr_ok, pay_ok, last_byte;
	logic [lpf_pkg::BYTE_W-1:0] hdr_low, hdr_high, pay_low, pay_high;

	always_comb begin
		hdr_ok    = (operation == lpf_pkg::OP_HEADER) && !open_q &&
			(payload_length <= MAX_LEN);
		pay_ok    = (operation == lpf_pkg::OP_PAYLOAD) && open_q;
		last_byte = (remaining_q == lpf_pkg::BYTE_W'(1));
		hdr_low   = packet_type + payload_length;
		hdr_high  = packet_type + hdr_low;
		pay_low   = sum_low_q + data_byte;
		pay_high  = sum_high_q + pay_low;
	end

	always_comb begin
		frame = '0;
		if (hdr_ok) begin
			frame.ent[0] = '{tx_byte: start_one_q, frame_end: 1'b0, error: 1'b0};
			frame.ent[1] = '{tx_byte: start_two_q, frame_end: 1'b0, error: 1'b0};
			frame.ent[2] = '{tx_byte: packet_type, frame_end: 1'b0, error: 1'b0};
			frame.ent[3] = '{tx_byte: payload_length,
				frame_end: (payload_length != '0), error: 1'b0};
			frame.ent[4] = '{tx_byte: hdr_low, frame_end: 1'b0, error: 1'b0};
			frame.ent[5] = '{tx_byte: hdr_high, frame_end: 1'b1, error: 1'b0};
			frame.count  = (payload_length == '0) ? lpf_pkg::CNT_W'(6) :
				lpf_pkg::CNT_W'(4);
		end else if (pay_ok) begin
			frame.ent[0] = '{tx_byte: data_byte, frame_end: !last_byte, error: 1'b0};
			frame.ent[1] = '{tx_byte: pay_low, frame_end: 1'b0, error: 1'b0};
			frame.ent[2] = '{tx_byte: pay_high, frame_end: 1'b1, error: 1'b0};
			frame.count  = last_byte ? lpf_pkg::CNT_W'(3) : lpf_pkg::CNT_W'(1);
		end else begin
			frame.ent[0] = '{tx_byte: '0, frame_end: 1'b1, error: 1'b1};
			frame.count  = lpf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_one_q <= '0;
			start_two_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lpf_pkg::REG_START_ONE: start_one_q <= cfg_data;
				lpf_pkg::REG_START_TWO: start_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance packet state on accepted transactions only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= '0;
			sum_low_q   <= '0;
			sum_high_q  <= '0;
		end else if (load) begin
			if (hdr_ok) begin
				open_q      <= (payload_length != '0);
				remaining_q <= payload_length;
				sum_low_q   <= hdr_low;
				sum_high_q  <= hdr_high;
			end else if (pay_ok) begin
				open_q      <= !last_byte;
				remaining_q <= remaining_q - lpf_pkg::BYTE_W'(1);
				sum_low_q   <= pay_low;
				sum_high_q  <= pay_high;
			end
		end
	end

endmodule

// ===== sv/lpf_emitter.sv =====
// ----------------------------------------------------------------------------
// lpf_emitter: result register and byte sequencer
// Holds up to six results of one transaction and presents them in order,
// taking the next frame as the last result leaves.
// ----------------------------------------------------------------------------
module lpf_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  lpf_pkg::frame_t             frame,
	output logic                        can_load,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lpf_pkg::BYTE_W-1:0]  tx_byte,
	output logic                        frame_end,
	output logic                        error
);

	lpf_pkg::result_t [lpf_pkg::MAX_RES-1:0] ent_q;
	logic [lpf_pkg::CNT_W-1:0]               count_q;
	logic                                    pop;

	always_comb begin
		out_valid = (count_q != '0);
		pop       = out_valid && out_ready;
		can_load  = (count_q == '0) ||
			((count_q == lpf_pkg::CNT_W'(1)) && out_ready);
		tx_byte   = ent_q[0].tx_byte;
		frame_end = ent_q[0].frame_end;
		error     = ent_q[0].error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= frame.count;
		end else if (pop) begin
			count_q <= count_q - lpf_pkg::CNT_W'(1);
		end
	end

	// shift results down as each result leaves
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= frame.ent;
		end else if (pop) begin
			for (int i = 0; i < lpf_pkg::MAX_RES - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
			ent_q[lpf_pkg::MAX_RES-1] <= '0;
		end
	end

endmodule

// ===== sv/link_packet_framer_fletcher8.sv =====
// ----------------------------------------------------------------------------
// link_packet_framer_fletcher8: link packet framer with mod-256 checksum
// Turns header and payload transactions into a framed byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): operation selects header or payload
// byte; a header carries packet_type and payload_length, a payload item
// carries data_byte. Output channel (out_valid/out_ready) moves one byte a
// transaction with frame_end on the last byte of an item and error on a
// rejected item (tx_byte zero).
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the two start
// bytes; cfg_ready is always high, unknown indexes are dropped.
// The first byte of an item is registered and appears in the cycle after acceptance.
// An item emits one byte for a payload byte or an error, three for the
// last payload byte, four or six for a header. The six-entry result
// register holds these bytes; the next item is taken in the cycle its
// predecessor's last byte leaves.
// Reset clears the start bytes, packet state, sums and the result count; the result entries are not reset.
// A stalled receiver holds the current byte and, while the register holds
// any result, holds in_ready low.
// ----------------------------------------------------------------------------
module link_packet_framer_fletcher8 #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpf_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [lpf_pkg::BYTE_W-1:0]    packet_type,
	input  logic [lpf_pkg::BYTE_W-1:0]    payload_length,
	input  logic [lpf_pkg::BYTE_W-1:0]    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpf_pkg::BYTE_W-1:0]    tx_byte,
	output logic                          frame_end,
	output logic                          error
);

	lpf_pkg::frame_t frame;
	logic            load;

	assign cfg_ready = 1'b1;
	assign load      = in_valid && in_ready;

	lpf_engine #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.load           (load),
		.operation      (operation),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.frame          (frame)
	);

	lpf_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.frame     (frame),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.frame_end (frame_end),
		.error     (error)
	);

endmodule
